@@ rtl/core/bounded_request_tracker_defines.svh @@
// Assertion macros used by the tracker's datapath.
`ifndef BOUNDED_REQUEST_TRACKER_DEFINES_SVH
`define BOUNDED_REQUEST_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled in rst.
`define BRT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled in rst.
`define BRT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/brt_pkg.sv @@
// Types and constants shared by the request tracker modules.
package brt_pkg;

  localparam int ID_W     = 6;
  localparam int TAG_W    = 32;
  localparam int NOW_W    = 32;
  localparam int LIM_W    = 4;
  localparam int CFG_W    = 32;
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 40;

  localparam int S_ID_LO    = 0;
  localparam int S_NOW_LO   = 6;
  localparam int S_TAG_LO   = 38;
  localparam int S_OK_BIT   = 70;
  localparam int S_READY_LO = 71;

  typedef enum logic [1:0] {
    MODE_REQUEST  = 2'd0,
    MODE_CANCEL   = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_RESPONSE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_TIMEOUT  = 3'd1,
    KIND_CANCEL   = 3'd2,
    KIND_COMPLETE = 3'd3,
    KIND_DONE     = 3'd4
  } kind_t;

  localparam logic CFG_MAX_ACTIVE = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  localparam logic [LIM_W-1:0] MAX_ACTIVE_RST = 4'd8;
  localparam logic [CFG_W-1:0] TIMEOUT_RST    = 32'd1000;

  typedef struct packed {
    logic  latch;
    logic  apply;
    logic  sweep_init;
    logic  rd_ptr;
    logic  rd_next;
    logic  rd_head;
    logic  find_adv;
    logic  shift_wr;
    logic  shift_end;
    logic  scan_step;
    logic  gone_init;
    logic  gone_adv;
    logic  pop;
    logic  emit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  pend_hit;
    logic  acc;
    logic  ok;
    logic  found;
    logic  shift_more;
    logic  scan_last;
    logic  gone_hit;
    logic  fill_go;
    logic  pop_ready;
    logic  out_free;
  } stat_t;

endpackage

@@ rtl/core/brt_ram.sv @@
// Generic single-port-write RAM with a registered read port.
module brt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/brt_ctrl.sv @@
// Sequencing state machine of the request tracker.
module brt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  brt_pkg::stat_t st,
  output brt_pkg::cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_APPLY    = 14'h0002,
    S_FIND_RD  = 14'h0004,
    S_FIND_CHK = 14'h0008,
    S_SHIFT_RD = 14'h0010,
    S_SHIFT_WR = 14'h0020,
    S_CAN_EMIT = 14'h0040,
    S_SCAN     = 14'h0080,
    S_FILL_CHK = 14'h0100,
    S_FILL_POP = 14'h0200,
    S_GONE     = 14'h0400,
    S_COMP     = 14'h0800,
    S_FIN      = 14'h1000,
    S_SPARE    = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (st.mode == brt_pkg::MODE_CANCEL && st.pend_hit) begin
          cmd.sweep_init = 1'b1;
          state_next     = S_FIND_RD;
        end else if (st.mode == brt_pkg::MODE_CANCEL) begin
          state_next = S_CAN_EMIT;
        end else if (st.mode == brt_pkg::MODE_TICK) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FILL_CHK;
        end
      end
      S_FIND_RD: begin
        cmd.rd_ptr = 1'b1;
        state_next = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (st.found) begin
          state_next = S_SHIFT_RD;
        end else begin
          cmd.find_adv = 1'b1;
          state_next   = S_FIND_RD;
        end
      end
      S_SHIFT_RD: begin
        if (st.shift_more) begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end else begin
          cmd.shift_end = 1'b1;
          state_next    = S_CAN_EMIT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_CAN_EMIT: begin
        if (!st.acc) begin
          state_next = S_FILL_CHK;
        end else if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = brt_pkg::KIND_CANCEL;
          state_next = S_FILL_CHK;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = S_FILL_CHK;
        end
      end
      S_FILL_CHK: begin
        if (st.fill_go) begin
          cmd.rd_head = 1'b1;
          state_next  = S_FILL_POP;
        end else if (st.mode == brt_pkg::MODE_TICK) begin
          cmd.gone_init = 1'b1;
          state_next    = S_GONE;
        end else if (st.mode == brt_pkg::MODE_RESPONSE) begin
          state_next = S_COMP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FILL_POP: begin
        if (!st.pop_ready) begin
          cmd.pop    = 1'b1;
          state_next = S_FILL_CHK;
        end else if (st.out_free) begin
          cmd.pop    = 1'b1;
          cmd.emit   = 1'b1;
          cmd.kind   = brt_pkg::KIND_START;
          state_next = S_FILL_CHK;
        end
      end
      S_GONE: begin
        if (!st.gone_hit || st.out_free) begin
          cmd.gone_adv = 1'b1;
          cmd.emit     = st.gone_hit;
          cmd.kind     = brt_pkg::KIND_TIMEOUT;
          if (st.scan_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_COMP: begin
        if (!(st.acc && st.ok)) begin
          state_next = S_FIN;
        end else if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = brt_pkg::KIND_COMPLETE;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = brt_pkg::KIND_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/brt_dp.sv @@
// Datapath of the request tracker: pending queue, slot table and result register.
`include "bounded_request_tracker_defines.svh"

module brt_dp #(
  parameter int MAX_SLOTS  = 8,
  parameter int NODE_COUNT = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [brt_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                     s_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_index,
  input  logic [brt_pkg::CFG_W-1:0]      cfg_data,
  input  brt_pkg::cmd_t                  cmd,
  output brt_pkg::stat_t                 st,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [brt_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [2:0]                     m_tuser,
  output logic                           m_tlast
);

  localparam int PW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int QW   = $clog2(NODE_COUNT + 1);
  localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int AW   = $clog2(MAX_SLOTS + 1);
  localparam int CW   = (TIME_WIDTH > brt_pkg::NOW_W) ? TIME_WIDTH : brt_pkg::NOW_W;
  localparam int ID_W = brt_pkg::ID_W;
  localparam int TG_W = brt_pkg::TAG_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(NODE_COUNT - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  logic [brt_pkg::LIM_W-1:0] max_active;
  logic [brt_pkg::CFG_W-1:0] timeout;

  brt_pkg::mode_t          mode_q;
  logic [ID_W-1:0]         id_q;
  logic [TIME_WIDTH-1:0]   now_q;
  logic [TG_W-1:0]         tag_q;
  logic                    ok_q;
  logic [NODE_COUNT-1:0]   ready_q;
  logic                    acc_q;
  logic [CW-1:0]           now_ext;

  logic [PW-1:0]           head;
  logic [PW-1:0]           tail;
  logic [QW-1:0]           pend_count;
  logic [NODE_COUNT-1:0]   pend_mark;
  logic [PW-1:0]           ptr;
  logic [QW-1:0]           idx;

  logic [MAX_SLOTS-1:0]    slot_valid;
  logic [PW-1:0]           slot_node  [MAX_SLOTS];
  logic [TIME_WIDTH-1:0]   slot_start [MAX_SLOTS];
  logic [TG_W-1:0]         slot_tag   [MAX_SLOTS];
  logic [TG_W-1:0]         next_tag;

  logic [SW-1:0]           sc;
  logic [MAX_SLOTS-1:0]    gone_mask;
  logic [PW-1:0]           gone_node  [MAX_SLOTS];

  brt_pkg::kind_t          out_kind;
  logic [ID_W-1:0]         out_id;
  logic [TG_W-1:0]         out_tag;
  logic                    out_acc;
  logic                    out_last;

  logic                    ram_we;
  logic [PW-1:0]           ram_waddr;
  logic [PW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [PW-1:0]           ram_raddr;
  logic [PW-1:0]           ram_rdata;

  logic                    in_range;
  logic [PW-1:0]           id_idx;
  logic                    mark_bit;
  logic                    req_ok;
  logic [MAX_SLOTS-1:0]    act_hit;
  logic [MAX_SLOTS-1:0]    tag_hit;
  logic [SW-1:0]           free_idx;
  logic [AW-1:0]           active;
  logic [4:0]              lim;
  logic [TIME_WIDTH-1:0]   age;
  logic                    expired;
  logic                    out_free;
  logic                    pop_ready;

  assign now_ext  = CW'(s_tdata[brt_pkg::S_NOW_LO +: brt_pkg::NOW_W]);
  assign in_range = ({1'b0, id_q} < (ID_W + 1)'(NODE_COUNT));
  assign id_idx   = id_q[PW-1:0];
  assign mark_bit = in_range && pend_mark[id_idx];

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      act_hit[s] = slot_valid[s] && in_range && (slot_node[s] == id_idx);
      tag_hit[s] = act_hit[s] && (slot_tag[s] == tag_q);
    end
  end

  always_comb begin
    free_idx = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (!slot_valid[s]) begin
        free_idx = SW'(s);
      end
    end
  end

  assign req_ok  = in_range && !(|act_hit) && !pend_mark[id_idx] &&
                   (pend_count < QW'(NODE_COUNT));
  assign active  = AW'($countones(slot_valid));
  assign lim     = ({1'b0, max_active} > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS) : {1'b0, max_active};
  assign age     = now_q - slot_start[sc];
  assign expired = slot_valid[sc] && (CW'(age) > CW'(timeout));
  assign out_free  = !m_tvalid || m_tready;
  assign pop_ready = ready_q[ram_rdata];

  assign st.mode       = mode_q;
  assign st.pend_hit   = mark_bit;
  assign st.acc        = acc_q;
  assign st.ok         = ok_q;
  assign st.found      = (ram_rdata == id_idx);
  assign st.shift_more = ((idx + QW'(1)) < pend_count);
  assign st.scan_last  = (sc == SW'(MAX_SLOTS - 1));
  assign st.gone_hit   = gone_mask[sc];
  assign st.fill_go    = (5'(active) < lim) && (pend_count != '0);
  assign st.pop_ready  = pop_ready;
  assign st.out_free   = out_free;

  assign ram_we    = (cmd.apply && mode_q == brt_pkg::MODE_REQUEST && req_ok) || cmd.shift_wr;
  assign ram_waddr = cmd.shift_wr ? ptr : tail;
  assign ram_wdata = cmd.shift_wr ? ram_rdata : id_idx;
  assign ram_re    = cmd.rd_ptr || cmd.rd_next || cmd.rd_head;
  assign ram_raddr = cmd.rd_head ? head : (cmd.rd_next ? ptr_inc(ptr) : ptr);

  brt_ram #(
    .WIDTH (PW),
    .DEPTH (NODE_COUNT)
  ) u_pend_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_active <= brt_pkg::MAX_ACTIVE_RST;
      timeout    <= brt_pkg::TIMEOUT_RST;
      head       <= '0;
      tail       <= '0;
      pend_count <= '0;
      pend_mark  <= '0;
      slot_valid <= '0;
      next_tag   <= '0;
      acc_q      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          brt_pkg::CFG_MAX_ACTIVE: max_active <= cfg_data[brt_pkg::LIM_W-1:0];
          brt_pkg::CFG_TIMEOUT:    timeout    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.latch) begin
        acc_q <= 1'b0;
      end
      if (cmd.apply) begin
        case (mode_q)
          brt_pkg::MODE_REQUEST: begin
            if (req_ok) begin
              tail              <= ptr_inc(tail);
              pend_count        <= pend_count + 1'b1;
              pend_mark[id_idx] <= 1'b1;
              acc_q             <= 1'b1;
            end
          end
          brt_pkg::MODE_CANCEL: begin
            if (mark_bit) begin
              pend_mark[id_idx] <= 1'b0;
              acc_q             <= 1'b1;
            end
            if (|act_hit) begin
              slot_valid <= slot_valid & ~act_hit;
              acc_q      <= 1'b1;
            end
          end
          brt_pkg::MODE_RESPONSE: begin
            if (|tag_hit) begin
              slot_valid <= slot_valid & ~tag_hit;
              acc_q      <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.shift_end) begin
        pend_count <= pend_count - 1'b1;
        tail       <= ptr;
      end
      if (cmd.scan_step && expired) begin
        slot_valid[sc] <= 1'b0;
      end
      if (cmd.pop) begin
        head                 <= ptr_inc(head);
        pend_count           <= pend_count - 1'b1;
        pend_mark[ram_rdata] <= 1'b0;
        if (pop_ready) begin
          slot_valid[free_idx] <= 1'b1;
          next_tag             <= next_tag + 1'b1;
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q    <= brt_pkg::mode_t'(s_tuser);
      id_q      <= s_tdata[brt_pkg::S_ID_LO +: ID_W];
      now_q     <= now_ext[TIME_WIDTH-1:0];
      tag_q     <= s_tdata[brt_pkg::S_TAG_LO +: TG_W];
      ok_q      <= s_tdata[brt_pkg::S_OK_BIT];
      ready_q   <= s_tdata[brt_pkg::S_READY_LO +: NODE_COUNT];
      sc        <= '0;
      gone_mask <= '0;
    end
    if (cmd.sweep_init) begin
      ptr <= head;
      idx <= '0;
    end
    if (cmd.find_adv || cmd.shift_wr) begin
      ptr <= ptr_inc(ptr);
      idx <= idx + 1'b1;
    end
    if (cmd.scan_step) begin
      if (expired) begin
        gone_mask[sc] <= 1'b1;
        gone_node[sc] <= slot_node[sc];
      end
      if (!st.scan_last) begin
        sc <= sc + 1'b1;
      end
    end
    if (cmd.gone_init) begin
      sc <= '0;
    end
    if (cmd.gone_adv && !st.scan_last) begin
      sc <= sc + 1'b1;
    end
    if (cmd.pop && pop_ready) begin
      slot_node[free_idx]  <= ram_rdata;
      slot_start[free_idx] <= now_q;
      slot_tag[free_idx]   <= next_tag;
    end
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      case (cmd.kind)
        brt_pkg::KIND_START: begin
          out_id   <= ID_W'(ram_rdata);
          out_tag  <= next_tag;
          out_acc  <= 1'b0;
          out_last <= 1'b0;
        end
        brt_pkg::KIND_TIMEOUT: begin
          out_id   <= ID_W'(gone_node[sc]);
          out_tag  <= '0;
          out_acc  <= 1'b0;
          out_last <= 1'b0;
        end
        brt_pkg::KIND_CANCEL, brt_pkg::KIND_COMPLETE: begin
          out_id   <= id_q;
          out_tag  <= '0;
          out_acc  <= 1'b0;
          out_last <= 1'b0;
        end
        brt_pkg::KIND_DONE: begin
          out_id   <= (mode_q == brt_pkg::MODE_TICK) ? '0 : id_q;
          out_tag  <= '0;
          out_acc  <= acc_q;
          out_last <= 1'b1;
        end
        default: begin
          out_id   <= '0;
          out_tag  <= '0;
          out_acc  <= 1'b0;
          out_last <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, out_acc, out_tag, out_id};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  `BRT_ASSERT_IMP(a_emit_free, cmd.emit, out_free, "result issued while output register is held")
  `BRT_ASSERT_IMP(a_empty_ptrs, pend_count == '0, head == tail, "empty queue with unequal pointers")
  `BRT_ASSERT_IMP(a_count_max, 1'b1, pend_count <= QW'(NODE_COUNT), "pending count beyond capacity")
  `BRT_ASSERT_NXT(a_pop_start, cmd.pop && pop_ready, m_tvalid && out_kind == brt_pkg::KIND_START,
                  "started call not presented")

endmodule

@@ rtl/core/bounded_request_tracker.sv @@
// Top level of the outstanding request tracker with timeout.
// The slave channel takes one request at a time: tuser holds the mode (request, cancel,
// tick, response) and tdata the node id, time, tag, list status and reachability mask.
// Each request yields a run of results on the master channel: start calls, cancelled,
// timed out and completed notices, and always a closing done result marked by tlast.
// The configuration channel writes the concurrency limit (index 0) and timeout (index 1);
// it is always ready; the user must write it only while no request is in progress,
// which the block does not enforce. A plain request passes through apply, a fill check
// and the done result; a cancel or a response adds a state for its notice, and each
// pending id moved into a slot or dropped adds a fill check and a pop. A tick adds an age
// scan over every slot and a pass over every slot for reporting expiries. A cancel of a
// queued id adds a search of the queue and its compaction, a read and a write per later
// entry, through the pending memory with its single write port.
// The next request is accepted once the done result sits in the output register.
// Reset empties the queue and the slot table, clears the tag counter and restores the
// limit of 8 and timeout of 1000. When the receiver stalls, the block holds the current
// result and waits before producing the next one.
module bounded_request_tracker #(
  parameter int MAX_SLOTS  = 8,
  parameter int NODE_COUNT = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // node_id[5:0], now[37:6], tag_in[69:38], listed_ok[70], ready_mask[134:71], zero pad
  input  logic [brt_pkg::S_DATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_id[5:0], tag_out[37:6], accepted[38], zero pad
  output logic [brt_pkg::M_DATA_W-1:0] m_tdata,
  // kind[2:0]
  output logic [2:0]                   m_tuser,
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [brt_pkg::CFG_W-1:0]    cfg_data
);

  brt_pkg::cmd_t  cmd;
  brt_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  brt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  brt_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .NODE_COUNT (NODE_COUNT),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
